### hdl/ffc_pkg.sv
`timescale 1ns / 1ps
package ffc_pkg;

  localparam int ValueBitsDefault = 32;
  localparam int OutBits = 32;

  // Key event kinds.
  localparam logic [2:0] KIND_DIGIT    = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_EQUALS   = 3'd2;
  localparam logic [2:0] KIND_SIGN     = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;
  localparam logic [2:0] KIND_ALLCLEAR = 3'd5;

  // Operators.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Entry modes.
  localparam logic [2:0] MODE_WAIT_FIRST  = 3'd0;
  localparam logic [2:0] MODE_READ_FIRST  = 3'd1;
  localparam logic [2:0] MODE_WAIT_SECOND = 3'd2;
  localparam logic [2:0] MODE_READ_SECOND = 3'd3;
  localparam logic [2:0] MODE_ANSWER      = 3'd4;
  localparam logic [2:0] MODE_READ_OVER   = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
    logic [1:0] op_select;
  } key_in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] entry_value;
    logic signed [OutBits-1:0] accumulator_value;
    logic [2:0]                mode_now;
    logic                      div_refused;
  } calc_out_t;

endpackage

### hdl/four_function_calculator_control.sv
`timescale 1ns / 1ps
// Add, subtract, sign and clear keys go straight to the finish state and the result;
// a digit, a multiply and a divide first run the shift-add or restoring divide loop.
// Keys are taken one at a time: in_stall is held while the bit-serial shift-add or
// restoring divide loop runs and while a result waits under out_stall.
// Reset: synchronous active-low rst_n returns to wait-first with entry and accumulator zero.
module four_function_calculator_control
  import ffc_pkg::*;
#(
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  key_in_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output calc_out_t out_data
);

  localparam int CntBits = $clog2(VALUE_BITS + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIGIT  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            st_r, st_nxt;
  logic [2:0]            mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]            pop_r, pop_nxt;
  logic [VALUE_BITS-1:0] mc_r, mc_nxt;       // multiplicand or divisor
  logic [VALUE_BITS-1:0] mp_r, mp_nxt;       // multiplier or dividend/quotient
  logic [VALUE_BITS-1:0] prod_r, prod_nxt;   // product or remainder
  logic [CntBits-1:0]    cnt_r, cnt_nxt;
  logic                  qneg_r, qneg_nxt;
  logic [2:0]            tmode_r, tmode_nxt;  // mode after a pending operation, or low digit bits
  logic [1:0]            top_r, top_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic                  refused_r, refused_nxt;

  logic                  in_fire;
  logic [VALUE_BITS-1:0] sentry, abs_a, abs_b, rem_try;
  logic [VALUE_BITS:0]   rem_sub;

  assign in_fire = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || (ovalid_r && out_stall);
  assign sentry = neg_r ? (VALUE_BITS'(0) - mag_r) : mag_r;
  assign abs_a = acc_r[VALUE_BITS-1] ? (VALUE_BITS'(0) - acc_r) : acc_r;
  assign abs_b = sentry[VALUE_BITS-1] ? (VALUE_BITS'(0) - sentry) : sentry;
  assign rem_try = {prod_r[VALUE_BITS-2:0], mp_r[VALUE_BITS-1]};
  assign rem_sub = {1'b0, rem_try} - {1'b0, mc_r};

  // Key decode, bit-serial multiply and restoring divide.
  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; mag_nxt = mag_r; neg_nxt = neg_r;
    acc_nxt = acc_r; pop_nxt = pop_r; mc_nxt = mc_r; mp_nxt = mp_r;
    prod_nxt = prod_r; cnt_nxt = cnt_r; qneg_nxt = qneg_r; tmode_nxt = tmode_r;
    top_nxt = top_r; refused_nxt = refused_r;
    ovalid_nxt = ovalid_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          refused_nxt = 1'b0;
          st_nxt = ST_FINISH;
          if (mode_r <= MODE_READ_OVER) begin
            case (in_data.kind)
              KIND_DIGIT: begin
                // magnitude * 10 serially, digit added at the end
                mc_nxt = mag_r;
                mp_nxt = VALUE_BITS'(10);
                prod_nxt = '0;
                cnt_nxt = CntBits'(VALUE_BITS);
                top_nxt = 2'(in_data.digit[3:2]);
                tmode_nxt = {1'b0, in_data.digit[1:0]};
                st_nxt = ST_DIGIT;
              end
              KIND_OPERATOR, KIND_EQUALS: begin
                top_nxt = in_data.op_select;
                tmode_nxt = (in_data.kind == KIND_EQUALS) ? MODE_ANSWER : MODE_WAIT_SECOND;
                if (in_data.kind == KIND_OPERATOR &&
                    (mode_r == MODE_READ_FIRST || mode_r == MODE_READ_OVER)) begin
                  acc_nxt = sentry; mag_nxt = '0; neg_nxt = 1'b0;
                  pop_nxt = in_data.op_select; mode_nxt = MODE_WAIT_SECOND;
                end else if (in_data.kind == KIND_OPERATOR && mode_r == MODE_ANSWER) begin
                  pop_nxt = in_data.op_select; mag_nxt = '0; neg_nxt = 1'b0;
                  mode_nxt = MODE_WAIT_SECOND;
                end else if (mode_r == MODE_READ_SECOND) begin
                  case (pop_r)
                    OP_ADD, OP_SUB: begin
                      acc_nxt = (pop_r == OP_ADD) ? acc_r + sentry : acc_r - sentry;
                      mag_nxt = '0; neg_nxt = 1'b0; mode_nxt = tmode_nxt;
                      if (in_data.kind == KIND_OPERATOR) pop_nxt = in_data.op_select;
                    end
                    OP_MUL: begin
                      mc_nxt = acc_r; mp_nxt = sentry; prod_nxt = '0;
                      cnt_nxt = CntBits'(VALUE_BITS); st_nxt = ST_MUL;
                    end
                    default: begin
                      if (mag_r == '0) begin
                        refused_nxt = 1'b1;
                      end else begin
                        mc_nxt = abs_b; mp_nxt = abs_a; prod_nxt = '0;
                        qneg_nxt = acc_r[VALUE_BITS-1] ^ sentry[VALUE_BITS-1];
                        cnt_nxt = CntBits'(VALUE_BITS); st_nxt = ST_DIV;
                      end
                    end
                  endcase
                  if (in_data.kind == KIND_EQUALS) top_nxt = pop_r;
                end
              end
              KIND_SIGN: neg_nxt = !neg_r;
              KIND_CLEAR: begin
                mag_nxt = '0; neg_nxt = 1'b0;
                if (mode_r == MODE_READ_FIRST) mode_nxt = MODE_WAIT_FIRST;
                else if (mode_r == MODE_READ_SECOND) mode_nxt = MODE_WAIT_SECOND;
                else if (mode_r == MODE_READ_OVER) mode_nxt = MODE_ANSWER;
              end
              KIND_ALLCLEAR: begin
                acc_nxt = '0; pop_nxt = OP_ADD; mag_nxt = '0; neg_nxt = 1'b0;
                mode_nxt = MODE_WAIT_FIRST;
              end
              default: ;
            endcase
          end
        end
      end
      ST_DIGIT, ST_MUL: begin
        // One multiplier bit per cycle, shift-add.
        if (mp_r[0]) prod_nxt = prod_r + mc_r;
        mc_nxt = mc_r << 1;
        mp_nxt = mp_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CntBits'(1)) begin
          st_nxt = ST_FINISH;
          if (st_r == ST_DIGIT) begin
            mag_nxt = prod_nxt + VALUE_BITS'({top_r, tmode_r[1:0]});
            if (mode_r == MODE_WAIT_FIRST) mode_nxt = MODE_READ_FIRST;
            else if (mode_r == MODE_WAIT_SECOND) mode_nxt = MODE_READ_SECOND;
            else if (mode_r == MODE_ANSWER) mode_nxt = MODE_READ_OVER;
          end else begin
            acc_nxt = prod_nxt; mag_nxt = '0; neg_nxt = 1'b0; mode_nxt = tmode_r;
            pop_nxt = (tmode_r == MODE_WAIT_SECOND) ? top_r : pop_r;
          end
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle, restoring.
        mp_nxt = {mp_r[VALUE_BITS-2:0], !rem_sub[VALUE_BITS]};
        prod_nxt = rem_sub[VALUE_BITS] ? rem_try : rem_sub[VALUE_BITS-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CntBits'(1)) begin
          st_nxt = ST_FINISH;
          acc_nxt = qneg_r ? (VALUE_BITS'(0) - mp_nxt) : mp_nxt;
          mag_nxt = '0; neg_nxt = 1'b0; mode_nxt = tmode_r;
          pop_nxt = (tmode_r == MODE_WAIT_SECOND) ? top_r : pop_r;
        end
      end
      ST_FINISH: begin
        ovalid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; mode_r <= MODE_WAIT_FIRST; mag_r <= '0; neg_r <= 1'b0;
      acc_r <= '0; pop_r <= OP_ADD; ovalid_r <= 1'b0; refused_r <= 1'b0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; mag_r <= mag_nxt; neg_r <= neg_nxt;
      acc_r <= acc_nxt; pop_r <= pop_nxt; ovalid_r <= ovalid_nxt;
      refused_r <= refused_nxt;
    end
  end

  // Datapath working registers.
  always_ff @(posedge clk) begin
    mc_r <= mc_nxt; mp_r <= mp_nxt; prod_r <= prod_nxt; cnt_r <= cnt_nxt;
    qneg_r <= qneg_nxt; tmode_r <= tmode_nxt; top_r <= top_nxt;
  end

  // Result held while stalled; values sign-extended or truncated to 32 bits.
  assign out_valid = ovalid_r;
  assign out_data.entry_value = OutBits'(signed'(sentry));
  assign out_data.accumulator_value = OutBits'(signed'(acc_r));
  assign out_data.mode_now = mode_r;
  assign out_data.div_refused = refused_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall) else $error("transfer accepted while busy");
  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FINISH) |=> out_valid) else $error("result missing after finish");
  a_refused_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (refused_r && st_r == ST_FINISH) |-> (pop_r == OP_DIV && mag_r == '0))
    else $error("refusal without zero divisor");
`endif

endmodule
